### rtl/core/ghash_pkg.sv
`timescale 1ns / 1ps

package ghash_pkg;

    localparam int BLK_W   = 128;
    localparam int HALF_W  = 64;
    localparam int CNT_W   = 5;
    localparam int BYTES_W = 61;
    localparam int BLK_BYTES = 16;

    // action codes of an input item
    localparam logic [1:0] ACT_AAD    = 2'd0;
    localparam logic [1:0] ACT_DATA   = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    // configuration register indexes
    localparam logic CFG_KEY_HI = 1'b0;
    localparam logic CFG_KEY_LO = 1'b1;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(BLK_BYTES);

    typedef enum logic [1:0] {
        OP_AAD  = 2'd0,
        OP_DATA = 2'd1,
        OP_FIN  = 2'd2
    } t_op_kind;

    // one queued operation; for a finish, data holds the counter-block mask
    typedef struct packed {
        t_op_kind          kind;
        logic [BLK_W-1:0]  data;
        logic [CNT_W-1:0]  count;
        logic              check;
        logic [BLK_W-1:0]  expected;
    } t_op;

    typedef struct packed {
        logic full;
        logic head_valid;
    } t_q_stat;

    // X * H in the bit-reflected GF(2^128) of GCM; bit 127 is the x^0 term
    function automatic logic [BLK_W-1:0] gf_mul(input logic [BLK_W-1:0] a,
                                                input logic [BLK_W-1:0] h);
        logic [BLK_W-1:0]   ar;
        logic [BLK_W-1:0]   hr;
        logic [BLK_W-1:0]   low;
        logic [BLK_W-1:0]   res;
        logic [2*BLK_W-2:0] p;
        logic [BLK_W-2:0]   ph;
        logic [BLK_W+5:0]   f;
        logic [5:0]         o;
        logic [12:0]        g;
        for (int i = 0; i < BLK_W; i++) begin
            ar[i] = a[BLK_W-1-i];
            hr[i] = h[BLK_W-1-i];
        end
        // carry-less product, one output bit at a time
        for (int k = 0; k < 2*BLK_W-1; k++) begin
            p[k] = 1'b0;
            for (int i = 0; i < BLK_W; i++) begin
                if ((k - i >= 0) && (k - i < BLK_W)) begin
                    p[k] = p[k] ^ (ar[i] & hr[k-i]);
                end
            end
        end
        // fold the top half with x^128 = x^7 + x^2 + x + 1, twice
        ph  = p[2*BLK_W-2:BLK_W];
        f   = {7'b0, ph} ^ {6'b0, ph, 1'b0} ^ {5'b0, ph, 2'b0} ^ {ph, 7'b0};
        o   = f[BLK_W+5:BLK_W];
        g   = {7'b0, o} ^ {6'b0, o, 1'b0} ^ {5'b0, o, 2'b0} ^ {o, 7'b0};
        low = p[BLK_W-1:0] ^ f[BLK_W-1:0] ^ {{(BLK_W-13){1'b0}}, g};
        for (int i = 0; i < BLK_W; i++) begin
            res[i] = low[BLK_W-1-i];
        end
        return res;
    endfunction

endpackage

### rtl/core/ghash_in_if.sv
`timescale 1ns / 1ps

interface ghash_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    logic [4:0]  byte_count;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
    logic        check_tag;
    logic [63:0] expected_hi;
    logic [63:0] expected_lo;

    modport source (
        output valid, action, block_hi, block_lo, byte_count, mask_hi, mask_lo,
               check_tag, expected_hi, expected_lo,
        input  ready
    );
    modport sink (
        input  valid, action, block_hi, block_lo, byte_count, mask_hi, mask_lo,
               check_tag, expected_hi, expected_lo,
        output ready
    );
endinterface

### rtl/core/ghash_out_if.sv
`timescale 1ns / 1ps

interface ghash_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] tag_hi;
    logic [63:0] tag_lo;
    logic        tag_ok;

    modport source (
        output valid, tag_hi, tag_lo, tag_ok,
        input  ready
    );
    modport sink (
        input  valid, tag_hi, tag_lo, tag_ok,
        output ready
    );
endinterface

### rtl/core/ghash_front.sv
`timescale 1ns / 1ps

module ghash_front (
    ghash_in_if.sink          i_blk,
    input  ghash_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output ghash_pkg::t_op    o_push_op
);

    logic                              keep;
    logic [ghash_pkg::CNT_W-1:0]       cnt_sat;
    logic [ghash_pkg::BLK_W-1:0]       byte_mask;
    logic [ghash_pkg::BLK_W-1:0]       raw_blk;

    function automatic logic [ghash_pkg::CNT_W-1:0] CNT_W_EXT(input int v);
        return ghash_pkg::CNT_W'(v);
    endfunction

    assign i_blk.ready = !i_q_stat.full;
    assign raw_blk     = {i_blk.block_hi, i_blk.block_lo};
    assign cnt_sat     = (i_blk.byte_count > ghash_pkg::FULL_COUNT) ?
                         ghash_pkg::FULL_COUNT : i_blk.byte_count;

    // keep leading bytes below the count, byte 0 at the top
    always_comb begin
        for (int b = 0; b < ghash_pkg::BLK_BYTES; b++) begin
            byte_mask[ghash_pkg::BLK_W-1-8*b -: 8] =
                (CNT_W_EXT(b) < cnt_sat) ? 8'hFF : 8'h00;
        end
    end

    always_comb begin
        keep                = 1'b0;
        o_push_op.kind      = ghash_pkg::OP_AAD;
        o_push_op.data      = raw_blk & byte_mask;
        o_push_op.count     = cnt_sat;
        o_push_op.check     = i_blk.check_tag;
        o_push_op.expected  = {i_blk.expected_hi, i_blk.expected_lo};
        unique case (i_blk.action) inside
            ghash_pkg::ACT_AAD, ghash_pkg::ACT_DATA: begin
                // drop absorbs with no valid bytes
                keep           = (i_blk.byte_count != '0);
                o_push_op.kind = (i_blk.action == ghash_pkg::ACT_AAD) ?
                                 ghash_pkg::OP_AAD : ghash_pkg::OP_DATA;
            end
            ghash_pkg::ACT_FINISH: begin
                keep           = 1'b1;
                o_push_op.kind = ghash_pkg::OP_FIN;
                o_push_op.data = {i_blk.mask_hi, i_blk.mask_lo};
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_blk.valid && i_blk.ready && keep;

endmodule

### rtl/core/ghash_queue.sv
`timescale 1ns / 1ps

module ghash_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ghash_pkg::t_op     i_push_op,
    input  logic               i_pop,
    output ghash_pkg::t_q_stat o_stat,
    output ghash_pkg::t_op     o_head
);

    ghash_pkg::t_op r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;

    assign o_stat.full       = (r_cnt == 2'd2);
    assign o_stat.head_valid = (r_cnt != 2'd0);
    assign o_head            = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_op;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !(i_push && !i_pop))
        else $error("queue pushed while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != 2'd0))
        else $error("queue popped while empty");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers out of step with fill count");
`endif

endmodule

### rtl/core/ghash_back.sv
`timescale 1ns / 1ps

module ghash_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic                     i_cfg_addr,
    input  logic [63:0]              i_cfg_wdata,
    input  ghash_pkg::t_q_stat       i_q_stat,
    input  ghash_pkg::t_op           i_head,
    output logic                     o_pop,
    ghash_out_if.source              o_tag
);

    logic [ghash_pkg::HALF_W-1:0]  r_key_hi;
    logic [ghash_pkg::HALF_W-1:0]  r_key_lo;
    logic [ghash_pkg::BLK_W-1:0]   r_acc;
    logic [ghash_pkg::BYTES_W-1:0] r_aad_bytes;
    logic [ghash_pkg::BYTES_W-1:0] r_data_bytes;
    logic                          r_out_vld;
    logic [ghash_pkg::BLK_W-1:0]   r_tag;
    logic                          r_tag_ok;

    logic                          is_fin;
    logic                          out_space;
    logic [ghash_pkg::BLK_W-1:0]   mul_in;
    logic [ghash_pkg::BLK_W-1:0]   mul_out;
    logic [ghash_pkg::BLK_W-1:0]   tag;
    logic [ghash_pkg::BLK_W-1:0]   len_blk;

    assign is_fin    = (i_head.kind == ghash_pkg::OP_FIN);
    assign out_space = !r_out_vld || o_tag.ready;
    assign o_pop     = i_q_stat.head_valid && (!is_fin || out_space);

    // length block: AAD bits then data bits
    assign len_blk = {r_aad_bytes, 3'b000, r_data_bytes, 3'b000};
    assign mul_in  = r_acc ^ (is_fin ? len_blk : i_head.data);
    assign mul_out = ghash_pkg::gf_mul(mul_in, {r_key_hi, r_key_lo});
    assign tag     = mul_out ^ i_head.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi     <= '0;
            r_key_lo     <= '0;
            r_acc        <= '0;
            r_aad_bytes  <= '0;
            r_data_bytes <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_addr == ghash_pkg::CFG_KEY_HI) begin
                    r_key_hi <= i_cfg_wdata;
                end else begin
                    r_key_lo <= i_cfg_wdata;
                end
            end
            if (o_pop) begin
                case (i_head.kind)
                    ghash_pkg::OP_AAD: begin
                        r_acc       <= mul_out;
                        r_aad_bytes <= r_aad_bytes +
                                       ghash_pkg::BYTES_W'(i_head.count);
                    end
                    ghash_pkg::OP_DATA: begin
                        r_acc        <= mul_out;
                        r_data_bytes <= r_data_bytes +
                                        ghash_pkg::BYTES_W'(i_head.count);
                    end
                    default: begin
                        // finish: clear for the next message
                        r_acc        <= '0;
                        r_aad_bytes  <= '0;
                        r_data_bytes <= '0;
                    end
                endcase
            end
            if (o_pop && is_fin) begin
                r_out_vld <= 1'b1;
            end else if (o_tag.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_fin) begin
            r_tag    <= tag;
            r_tag_ok <= i_head.check && (tag == i_head.expected);
        end
    end

    assign o_tag.valid  = r_out_vld;
    assign o_tag.tag_hi = r_tag[ghash_pkg::BLK_W-1:ghash_pkg::HALF_W];
    assign o_tag.tag_lo = r_tag[ghash_pkg::HALF_W-1:0];
    assign o_tag.tag_ok = r_tag_ok;

`ifndef SYNTHESIS
    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && is_fin) |=> (r_acc == '0 && r_aad_bytes == '0 && r_data_bytes == '0))
        else $error("state not cleared after finish");
    a_fin_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && is_fin) |-> (!r_out_vld || o_tag.ready))
        else $error("finish retired over an untaken tag");
    a_fin_shows_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && is_fin) |=> r_out_vld)
        else $error("finish gave no tag");
`endif

endmodule

### rtl/core/gcm_ghash_tag_engine.sv
`timescale 1ns / 1ps

// GHASH tag engine of AES-GCM.
// Input channel i_blk: one item per 16-byte block. Action AAD or data
// absorbs the block (bytes past byte_count read as zero, counts above 16
// act as 16); action finish absorbs the AAD/data bit lengths, XORs in
// mask_hi/mask_lo and, if check_tag is set, compares with expected_hi/lo.
// Action 3 and absorbs with a zero count are taken and dropped.
// Output channel o_tag: one item per finish, tag_hi/tag_lo/tag_ok.
// Hash key H is written on the cfg port (index 0 high half, index 1 low
// half); the user must write it only while no item is in flight; the
// block does not enforce this. Throughput: one item per cycle while the
// queue has room and no finish waits on a stalled o_tag; each absorb is
// one full GF(2^128) multiply, combinational, fed back to the accumulator.
// An accepted item is written into a two-entry queue and retires from
// its head, after any items queued ahead; a finish registers its tag as
// it retires. A stalled o_tag holds the tag; absorbs behind it keep
// flowing, and a second finish waits in the queue until the tag is taken.
// Reset (synchronous, active low) clears H, accumulator and byte counts.
module gcm_ghash_tag_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_addr,
    input  logic [63:0] i_cfg_wdata,
    ghash_in_if.sink    i_blk,
    ghash_out_if.source o_tag
);

    ghash_pkg::t_q_stat q_stat;
    ghash_pkg::t_op     push_op;
    ghash_pkg::t_op     head;
    logic               push;
    logic               pop;

    ghash_front u_front (
        .i_blk     (i_blk),
        .i_q_stat  (q_stat),
        .o_push    (push),
        .o_push_op (push_op)
    );

    ghash_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .i_pop     (pop),
        .o_stat    (q_stat),
        .o_head    (head)
    );

    ghash_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_stat    (q_stat),
        .i_head      (head),
        .o_pop       (pop),
        .o_tag       (o_tag)
    );

endmodule
